[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent property checks on a clock, with reset as the disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[hdl/bfd_pkg.sv]
// ---------------------------------------------------------------------------
// bfd_pkg
// Types and constants of the x86 branch filter decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

    localparam logic [7:0] OP_CALL  = 8'hE8;
    localparam logic [7:0] OP_JMP   = 8'hE9;
    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [7:0] BYTE_FF  = 8'hFF;

    // most bytes one item can release
    localparam int EMIT_MAX = 5;
    // output queue depth and width of its fill count
    localparam int QDEPTH   = 8;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // bytes released by one item, in order, index 0 first
    typedef struct packed {
        logic [2:0]                   cnt;
        logic [EMIT_MAX-1:0][7:0]     bytes;
        logic [EMIT_MAX-1:0]          lasts;
    } t_emit;

    // filter core status toward the top level
    typedef struct packed {
        logic [2:0] held_cnt;   // bytes in the hold, 0..4
        logic [2:0] need;       // worst-case bytes the next item releases
    } t_core_stat;

endpackage

`default_nettype wire

[hdl/bfd_core.sv]
// ---------------------------------------------------------------------------
// bfd_core
// Branch filter state: opcode hold, block offsets and operand rewrite.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic                  i_enable,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_block_end,
    output bfd_pkg::t_emit             o_emit,
    output bfd_pkg::t_core_stat        o_stat
);

    logic [7:0]  r_held [4];
    logic [2:0]  r_held_cnt;
    logic [31:0] r_byte_off;
    logic [31:0] r_op_off;

    logic [2:0]  n_held_cnt;
    logic [31:0] n_op_off;
    logic        w_hold_wr;
    logic [1:0]  w_hold_idx;

    logic [31:0] w_opnd;
    logic [31:0] w_sub;
    logic [31:0] w_adj;
    logic [31:0] w_fix;
    logic        w_is_op;

    assign w_is_op = (i_data_byte == bfd_pkg::OP_CALL) || (i_data_byte == bfd_pkg::OP_JMP);

    // operand rewrite when the fourth operand byte is 00 or FF: absolute -> relative, top byte forced to 00 unless FF
    always_comb begin
        w_opnd = {i_data_byte, r_held[3], r_held[2], r_held[1]};
        w_sub  = w_opnd - r_op_off;
        w_adj  = w_sub;
        if (w_sub[31:24] != bfd_pkg::BYTE_FF) begin
            w_adj[31:24] = bfd_pkg::BYTE_00;
        end
        if ((i_data_byte == bfd_pkg::BYTE_00) || (i_data_byte == bfd_pkg::BYTE_FF)) begin
            w_fix = w_adj;
        end else begin
            w_fix = w_opnd;
        end
    end

    always_comb begin
        o_emit.cnt      = 3'd0;
        o_emit.bytes[0] = r_held[0];
        o_emit.bytes[1] = r_held[1];
        o_emit.bytes[2] = r_held[2];
        o_emit.bytes[3] = r_held[3];
        o_emit.bytes[4] = i_data_byte;
        o_emit.lasts    = '0;
        n_held_cnt      = r_held_cnt;
        n_op_off        = r_op_off;
        w_hold_wr       = 1'b0;
        w_hold_idx      = r_held_cnt[1:0];
        o_stat.held_cnt = r_held_cnt;
        o_stat.need     = 3'd5;
        unique case (r_held_cnt)
            3'd0: begin
                o_stat.need = 3'd1;
                if (i_enable && !i_block_end && w_is_op) begin
                    w_hold_wr  = 1'b1;
                    n_held_cnt = 3'd1;
                    n_op_off   = r_byte_off;
                end else begin
                    o_emit.cnt      = 3'd1;
                    o_emit.bytes[0] = i_data_byte;
                    o_emit.lasts[0] = i_block_end;
                end
            end
            3'd1, 3'd2, 3'd3: begin
                o_stat.need = r_held_cnt + 3'd1;
                if (!i_block_end) begin
                    w_hold_wr  = 1'b1;
                    n_held_cnt = r_held_cnt + 3'd1;
                end else begin
                    // hold cut by block end: flush unchanged
                    o_emit.cnt                  = r_held_cnt + 3'd1;
                    o_emit.bytes[r_held_cnt]    = i_data_byte;
                    o_emit.lasts                = 5'b00001 << r_held_cnt;
                    n_held_cnt                  = 3'd0;
                end
            end
            3'd4: begin
                o_emit.cnt      = 3'd5;
                o_emit.bytes[1] = w_fix[7:0];
                o_emit.bytes[2] = w_fix[15:8];
                o_emit.bytes[3] = w_fix[23:16];
                o_emit.bytes[4] = w_fix[31:24];
                o_emit.lasts[4] = i_block_end;
                n_held_cnt      = 3'd0;
            end
            default: begin
                n_held_cnt = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 3'd0;
            r_byte_off <= '0;
            r_op_off   <= '0;
        end else if (i_fire) begin
            r_held_cnt <= n_held_cnt;
            r_op_off   <= n_op_off;
            r_byte_off <= i_block_end ? 32'd0 : r_byte_off + 32'd1;
        end
    end

    // hold bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && w_hold_wr) begin
            r_held[w_hold_idx] <= i_data_byte;
        end
    end

endmodule

`default_nettype wire

[hdl/bfd_outq.sv]
// ---------------------------------------------------------------------------
// bfd_outq
// Output queue: takes up to five bytes per cycle, gives one per cycle while popped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  bfd_pkg::t_emit                     i_emit,
    input  wire logic                          i_pop,
    output logic [bfd_pkg::QCNT_W-1:0]         o_fill,
    output logic [7:0]                         o_byte,
    output logic                               o_last
);

    localparam int D = bfd_pkg::QDEPTH;
    localparam int W = bfd_pkg::QCNT_W;

    logic [7:0]   r_q_byte [D];
    logic         r_q_last [D];
    logic [W-1:0] r_cnt;

    logic [7:0]   n_q_byte [D];
    logic         n_q_last [D];
    logic [W-1:0] n_cnt;

    // queue padded by one empty slot so the shift never indexes past the end
    logic [7:0]   w_ext_byte [D+1];
    logic         w_ext_last [D+1];

    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_ext_byte[i] = r_q_byte[i];
            w_ext_last[i] = r_q_last[i];
        end
        w_ext_byte[D] = '0;
        w_ext_last[D] = 1'b0;
    end

    always_comb begin
        logic [W-1:0] src;
        logic [W-1:0] j;
        for (int p = 0; p < D; p++) begin
            src = W'(p) + W'(i_pop);
            j   = src - r_cnt;
            n_q_byte[p] = r_q_byte[p];
            n_q_last[p] = r_q_last[p];
            if (src < r_cnt) begin
                n_q_byte[p] = w_ext_byte[src];
                n_q_last[p] = w_ext_last[src];
            end else if (i_wr && (j < W'(i_emit.cnt))) begin
                n_q_byte[p] = i_emit.bytes[j[2:0]];
                n_q_last[p] = i_emit.lasts[j[2:0]];
            end
        end
        n_cnt = r_cnt - W'(i_pop) + (i_wr ? W'(i_emit.cnt) : W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < D; p++) begin
            r_q_byte[p] <= n_q_byte[p];
            r_q_last[p] <= n_q_last[p];
        end
    end

    assign o_fill = r_cnt;
    assign o_byte = r_q_byte[0];
    assign o_last = r_q_last[0];

endmodule

`default_nettype wire

[hdl/x86_branch_filter_decoder.sv]
// ---------------------------------------------------------------------------
// x86_branch_filter_decoder
// Undoes the x86 call/jump address filter on a decompressed byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one byte item per cycle
//   with i_block_end on the last byte of each block. Output channel
//   (o_out_valid / i_out_ready) gives one byte item per cycle with
//   o_out_last on the final byte of the block.
//   Config channel (i_cfg_valid / o_cfg_ready) writes filter_enable; it is
//   always ready and should only be written while the block is idle.
//   Holding: a pass-through byte enters the output queue when it is
//   accepted and leaves from the queue head. An E8/E9 opcode and its first
//   three operand bytes are held; all five bytes enter the queue back to
//   back when the fourth operand byte is accepted.
//   Throughput: one byte per cycle in and out, sustained. The eight-entry
//   output queue absorbs the five-byte burst of a finished operand while
//   new bytes keep arriving; input stalls only when the queue lacks room
//   for the worst-case release of the next item.
//   Receiver stall: bytes wait in the queue; o_in_ready drops once it is
//   too full. Reset (synchronous, active low) empties the hold and the
//   queue, restarts the block offset at 0 and clears filter_enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module x86_branch_filter_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_filter_enable,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_block_end,
    // byte output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    localparam int W = bfd_pkg::QCNT_W;

    logic                   r_filter_enable;
    logic                   w_in_fire;
    logic                   w_out_fire;
    logic                   w_q_wr;
    logic [W-1:0]           w_fill;
    logic [W:0]             w_room_need;
    logic                   w_end_fire;
    logic                   w_full_fire;
    bfd_pkg::t_emit         w_emit;
    bfd_pkg::t_core_stat    w_stat;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_filter_enable <= i_cfg_filter_enable;
        end
    end

    // accept only when the queue can hold the worst-case release
    assign w_room_need = {1'b0, w_fill} + (W+1)'(w_stat.need);
    assign o_in_ready  = (w_room_need <= (W+1)'(bfd_pkg::QDEPTH));
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign o_out_valid = (w_fill != '0);
    assign w_out_fire  = o_out_valid && i_out_ready;

    assign w_q_wr = w_in_fire && (w_emit.cnt != 3'd0);

    // accepted item that ends a block / completes a full hold
    assign w_end_fire  = w_in_fire && i_block_end;
    assign w_full_fire = w_in_fire && (w_stat.held_cnt == 3'd4);

    bfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_in_fire),
        .i_enable    (r_filter_enable),
        .i_data_byte (i_data_byte),
        .i_block_end (i_block_end),
        .o_emit      (w_emit),
        .o_stat      (w_stat)
    );

    bfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_emit  (w_emit),
        .i_pop   (w_out_fire),
        .o_fill  (w_fill),
        .o_byte  (o_out_byte),
        .o_last  (o_out_last)
    );

    // hold never grows past opcode plus three operand bytes
    `ASSERT_NEVER(a_hold_bound, i_clk, i_rst_n, w_stat.held_cnt > 3'd4)
    // a block end always leaves the hold empty
    `ASSERT_PROP(a_end_flush, i_clk, i_rst_n, w_end_fire |=> (w_stat.held_cnt == 3'd0))
    // a full hold releases all five bytes on the next item
    `ASSERT_PROP(a_full_emit, i_clk, i_rst_n, w_full_fire |-> (w_emit.cnt == 3'd5))
    // with no write and no read the queue fill stays put
    `ASSERT_PROP(a_fill_hold, i_clk, i_rst_n, (!w_q_wr && !w_out_fire) |=> $stable(w_fill))

endmodule

`default_nettype wire

[verif/x86_branch_filter_decoder_tb.sv]
// ----------------------------------------------------------------------------
// x86_branch_filter_decoder_tb
// Self-checking testbench for the x86 call/jump branch filter decoder.
// Byte items stream in on a valid/ready channel and are mirrored by an
// in-bench unfilter predictor. Every output byte is checked in order against
// the predicted stream. Directed cases come first, then random blocks, with
// random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_branch_filter_decoder_tb;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 7;
    // a finished operand enters the output queue with its last byte; leave margin
    localparam int          DRAIN_CYCLES = 8;
    // receiver hold-off length, well past what the output queue can absorb
    localparam int          HOLD_CYCLES  = 120;
    // cycles without any handshake before the run is declared hung
    localparam int          STALL_LIMIT  = 2000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [7:0]  TOP_KEEP     = 8'hFF;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_out_item;

    typedef logic [7:0] t_byte_q[$];

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,    // always ready
        RX_SPARSE,  // ready with a chance of three in four, at random
        RX_THIRDS,  // fixed pattern: stalls whenever the phase count is a multiple of three
        RX_COIN     // ready half the time, at random
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time 0
    // ------------------------------------------------------------------------
    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_cfg_valid         = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_filter_enable = 1'b0;
    logic       i_in_valid          = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte         = 8'h00;
    logic       i_block_end         = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready         = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    x86_branch_filter_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_filter_enable (i_cfg_filter_enable),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_block_end         (i_block_end),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_byte          (o_out_byte),
        .o_out_last          (o_out_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Unfilter predictor state: its own copy of the hold, the block offsets
    // and filter_enable. Expected output bytes queue up in filtered_q.
    // ------------------------------------------------------------------------
    t_out_item   filtered_q[$];
    logic [7:0]  held[4];
    int          held_n    = 0;
    logic [31:0] blk_pos   = '0;
    logic [31:0] op_pos    = '0;
    logic        filt_en   = 1'b0;

    // run statistics
    int          items_sent    = 0;
    int          bytes_checked = 0;
    int          rewrites      = 0;
    int          cut_holds     = 0;
    int          cfg_writes    = 0;
    int          mismatches    = 0;

    // sender pacing
    bit          gaps_on     = 1'b1;
    int          burst_left  = 0;
    bit          offering    = 1'b0;
    realtime     drop_at     = -1.0;

    // receiver hold-off request, cleared by the receiver when done
    bit          hold_req    = 1'b0;

    function automatic void queue_out(input logic [7:0] data, input logic last);
        t_out_item it;
        it.data = data;
        it.last = last;
        filtered_q.push_back(it);
    endfunction

    // Advance the predictor by one accepted input item.
    function automatic void unfilter_byte(input logic [7:0] b, input logic last);
        logic [31:0] here;
        logic [31:0] operand;
        here    = blk_pos;
        blk_pos = last ? 32'd0 : blk_pos + 32'd1;

        if (held_n == 0) begin
            // only a new opcode with room left in the block starts a hold
            if (filt_en && !last &&
                (b == bfd_pkg::OP_CALL || b == bfd_pkg::OP_JMP)) begin
                held[0] = b;
                held_n  = 1;
                op_pos  = here;
            end else begin
                queue_out(b, last);
            end
        end else if (held_n < 4) begin
            if (!last) begin
                held[held_n] = b;
                held_n++;
            end else begin
                // block ended inside the operand: release everything as is
                for (int k = 0; k < held_n; k++)
                    queue_out(held[k], 1'b0);
                queue_out(b, 1'b1);
                held_n = 0;
                cut_holds++;
            end
        end else begin
            // b is the fourth operand byte; operand is little endian
            operand = {b, held[3], held[2], held[1]};
            if (b == bfd_pkg::BYTE_00 || b == bfd_pkg::BYTE_FF) begin
                operand = operand - op_pos;
                if (operand[31:24] != TOP_KEEP)
                    operand[31:24] = 8'h00;
                rewrites++;
            end
            queue_out(held[0], 1'b0);
            queue_out(operand[7:0], 1'b0);
            queue_out(operand[15:8], 1'b0);
            queue_out(operand[23:16], 1'b0);
            queue_out(operand[31:24], last);
            held_n = 0;
        end
    endfunction

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------------
    // Output checker: every accepted output byte against the oldest expected.
    // Sampled at the edge, so values are the ones the DUT presented.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_output
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (filtered_q.size() == 0) begin
                flag_error($sformatf("unexpected output byte %02h last %0b",
                                     o_out_byte, o_out_last));
            end else begin
                want = filtered_q.pop_front();
                if (o_out_byte !== want.data)
                    flag_error($sformatf("out_byte: expected %02h, got %02h",
                                         want.data, o_out_byte));
                if (o_out_last !== want.last)
                    flag_error($sformatf("out_last: expected %0b, got %0b (byte %02h)",
                                         want.last, o_out_last, want.data));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on any channel resets the count.
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d bytes outstanding",
                         STALL_LIMIT, filtered_q.size());
                $display("x86_branch_filter_decoder test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between stall patterns for random stretches, and
    // on request holds ready low for HOLD_CYCLES so the DUT backs up.
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_rx_mode rx_mode;
        int       mode_left;
        int       phase;
        logic     rdy;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_SPARSE: rdy = ($urandom_range(0, 3) != 0);
                    RX_THIRDS: rdy = ((phase % 3) != 0);
                    default:   rdy = 1'($urandom_range(0, 1));
                endcase
                i_out_ready <= rdy;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Valid stays high across back-to-back items; a gap drops it.
    // With gaps_on set, works in bursts of random length with random gaps between them.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap > 0) begin
            if (offering) begin
                i_in_valid <= 1'b0;
                offering    = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        // valid was dropped in this very step: raise it on the next edge
        if (!offering && $realtime == drop_at)
            @(posedge i_clk);
        i_data_byte <= b;
        i_block_end <= last;
        if (!offering) begin
            i_in_valid <= 1'b1;
            offering    = 1'b1;
        end
        do @(posedge i_clk); while (!o_in_ready);
        unfilter_byte(b, last);
        items_sent++;
    endtask

    // Stop offering once a sequence is done.
    task automatic release_input();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
            drop_at     = $realtime;
        end
    endtask

    // Send a sequence as one block: block_end on its final byte.
    task automatic send_block(input t_byte_q blk);
        foreach (blk[i])
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    // filter_enable is written only once every expected byte is out,
    // plus a margin for an operand that may still be in flight.
    task automatic set_filter_enable(input logic en);
        release_input();
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_filter_enable <= en;
        i_cfg_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        filt_en = en;
        cfg_writes++;
    endtask

    // A block of random length: mostly opcode + operand groups and plain
    // bytes, truncated at the block end so some holds get cut.
    task automatic send_random_block();
        t_byte_q blk;
        int      len;
        int      r;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 48);
        while (blk.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                blk.push_back($urandom_range(0, 1) ? bfd_pkg::OP_CALL : bfd_pkg::OP_JMP);
                repeat (3) blk.push_back(8'($urandom_range(0, 255)));
                r = $urandom_range(0, 9);
                // the fourth operand byte decides whether the address is rewritten
                blk.push_back(r < 4 ? bfd_pkg::BYTE_00 :
                              r < 8 ? bfd_pkg::BYTE_FF : 8'($urandom_range(0, 255)));
            end else begin
                blk.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (blk.size() > len) void'(blk.pop_back());
        send_block(blk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // filter_enable comes out of reset at 0: opcodes pass untouched
    task automatic test_reset_passthrough();
        t_byte_q blk;
        blk = '{bfd_pkg::OP_CALL, bfd_pkg::BYTE_FF, bfd_pkg::BYTE_00};
        send_block(blk);
        release_input();
    endtask

    // address rewrite: wrap below zero, top byte kept at FF, top byte cleared,
    // and a fourth operand byte that leaves the address alone (on block end)
    task automatic test_operand_rewrite();
        t_byte_q blk;
        set_filter_enable(1'b1);
        blk = '{8'h00,
                bfd_pkg::OP_JMP,  8'h00, 8'h00, 8'h00, bfd_pkg::BYTE_00,
                bfd_pkg::OP_CALL, 8'h00, 8'h00, 8'h00, bfd_pkg::BYTE_FF,
                bfd_pkg::OP_CALL, 8'h01, 8'h02, 8'h03, 8'h7F};
        send_block(blk);
        release_input();
    endtask

    // block ends inside an operand, and an opcode as the last byte
    task automatic test_block_end_cuts();
        t_byte_q blk;
        blk = '{bfd_pkg::OP_CALL, 8'hAA, 8'hBB};
        send_block(blk);
        blk = '{bfd_pkg::OP_JMP};
        send_block(blk);
        release_input();
    endtask

    // enable drops while an operand is held: the hold still completes
    // filtered, only the next opcode sees the new setting
    task automatic test_enable_during_hold();
        send_byte(8'h55, 1'b0);
        send_byte(bfd_pkg::OP_CALL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        set_filter_enable(1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(bfd_pkg::BYTE_00, 1'b0);
        send_byte(bfd_pkg::OP_JMP, 1'b1);
        release_input();
    endtask

    task automatic test_random_blocks(input int n, input logic en, input bit gaps);
        int start;
        set_filter_enable(en);
        gaps_on = gaps;
        start   = items_sent;
        while (items_sent - start < n)
            send_random_block();
        release_input();
        gaps_on = 1'b1;
    endtask

    // loose bytes with opcodes and block ends at random; broken sequences
    task automatic test_noise(input int n);
        logic [7:0] b;
        int         r;
        set_filter_enable(1'b1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            b = (r < 2) ? bfd_pkg::OP_CALL :
                (r < 4) ? bfd_pkg::OP_JMP : 8'($urandom_range(0, 255));
            send_byte(b, (i == n - 1) || ($urandom_range(0, 7) == 0));
        end
        release_input();
    endtask

    // receiver holds off for a long stretch while the sender keeps going
    task automatic test_output_backpressure(input int n);
        int start;
        set_filter_enable(1'b1);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        start    = items_sent;
        while (items_sent - start < n)
            send_random_block();
        release_input();
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_operand_rewrite();
        test_block_end_cuts();
        test_enable_during_hold();

        test_random_blocks(90, 1'b1, 1'b1);
        test_random_blocks(40, 1'b0, 1'b1);
        test_output_backpressure(30);
        test_random_blocks(60, 1'b1, 1'b0);
        test_noise(50);
        test_random_blocks(30, 1'b1, 1'b1);

        // drain: everything predicted must come out; watchdog bounds the wait
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (filtered_q.size() != 0)
            flag_error($sformatf("%0d expected bytes never arrived", filtered_q.size()));

        $display("run: %0d bytes in, %0d bytes out checked, %0d mismatches",
                 items_sent, bytes_checked, mismatches);
        $display("     %0d operands rewritten, %0d holds cut by block end, %0d enable writes",
                 rewrites, cut_holds, cfg_writes);
        if (mismatches == 0) begin
            $display("x86_branch_filter_decoder test passed");
        end else begin
            $display("x86_branch_filter_decoder test failed");
        end
        $finish;
    end

endmodule

[x86_branch_filter_decoder.f]
+incdir+hdl
hdl/bfd_pkg.sv
hdl/bfd_core.sv
hdl/bfd_outq.sv
hdl/x86_branch_filter_decoder.sv
verif/x86_branch_filter_decoder_tb.sv
